@@ hdl/pcm_block_peak_envelope_macros.svh @@
`ifndef PCM_BLOCK_PEAK_ENVELOPE_MACROS_SVH
`define PCM_BLOCK_PEAK_ENVELOPE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PBPE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PBPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/pbpe_pkg.sv @@
`default_nettype none

package pbpe_pkg;

	localparam int MAX_CHANNELS     = 8;
	localparam int BLOCK_COUNT_BITS = 16;
	localparam int MAX_BPS          = 3;
	localparam int FRAME_W          = $clog2(MAX_BPS * MAX_CHANNELS + 1);
	localparam int CH_W             = $clog2(MAX_CHANNELS + 1);
	localparam int SAMPLE_W         = 24;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
	localparam logic [23:0] SPAN_LEAST_RESET = 24'd32767;

	typedef enum logic [1:0] {
		WIDTH_U8  = 2'd0,
		WIDTH_S16 = 2'd1,
		WIDTH_S24 = 2'd2
	} width_code_t;

	typedef enum logic [1:0] {
		REG_SAMPLE_WIDTH = 2'd0,
		REG_CHANNELS     = 2'd1,
		REG_BLOCK_BYTES  = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [1:0]  sample_width;
		logic [3:0]  channels;
		logic [15:0] block_bytes;
	} cfg_t;

	// One classified byte as handed from the front to the back.
	typedef struct packed {
		logic                       sample_vld;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       blk_end;
		logic                       strm_end;
	} entry_t;

	// A closed block waiting for span update.
	typedef struct packed {
		logic                       blk_valid;
		logic signed [SAMPLE_W-1:0] low;
		logic signed [SAMPLE_W-1:0] high;
		logic                       done;
	} block_t;

endpackage

`default_nettype wire

@@ hdl/pbpe_front.sv @@
`default_nettype none

module pbpe_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pbpe_pkg::cfg_t  cfg,
	input  wire logic            in_take,
	input  wire logic [7:0]      pcm_byte,
	input  wire logic            stream_end,
	output logic                 push,
	output pbpe_pkg::entry_t     entry
);
	import pbpe_pkg::*;

	logic [BLOCK_COUNT_BITS-1:0] blk_cnt_q;
	logic [FRAME_W-1:0]          frame_cnt_q;
	logic [15:0]                 partial_q;

	logic [FRAME_W-1:0]          bps;
	logic [FRAME_W-1:0]          ch;
	logic [FRAME_W-1:0]          frame;
	logic [FRAME_W-1:0]          pos;
	logic [FRAME_W-1:0]          pos_inc;
	logic [BLOCK_COUNT_BITS-1:0] count;
	logic [BLOCK_COUNT_BITS-1:0] blen;
	logic                        last_byte;
	logic signed [SAMPLE_W-1:0]  value;

	always_comb begin
		unique case (width_code_t'(cfg.sample_width))
			WIDTH_U8:  bps = FRAME_W'(1);
			WIDTH_S16: bps = FRAME_W'(2);
			default:   bps = FRAME_W'(3);
		endcase
		if (cfg.channels == 4'd0) begin
			ch = FRAME_W'(1);
		end else if (32'(cfg.channels) > MAX_CHANNELS) begin
			ch = FRAME_W'(MAX_CHANNELS);
		end else begin
			ch = FRAME_W'(cfg.channels);
		end
		frame   = ch * bps;
		pos     = (frame_cnt_q >= frame) ? '0 : frame_cnt_q;
		pos_inc = pos + FRAME_W'(1);
		count   = blk_cnt_q + BLOCK_COUNT_BITS'(1);
		blen    = BLOCK_COUNT_BITS'(cfg.block_bytes);

		unique case (width_code_t'(cfg.sample_width))
			WIDTH_U8:  value = {{16{~pcm_byte[7]}}, ~pcm_byte[7], pcm_byte[6:0]};
			WIDTH_S16: value = {{8{pcm_byte[7]}}, pcm_byte, partial_q[7:0]};
			default:   value = {pcm_byte, partial_q};
		endcase

		entry.sample_vld = (pos_inc == bps);
		entry.sample     = value;
		entry.blk_end    = (count == blen);
		entry.strm_end   = stream_end;
		last_byte        = entry.blk_end || stream_end;
		push             = in_take && (entry.sample_vld || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_cnt_q   <= '0;
			frame_cnt_q <= '0;
			partial_q   <= '0;
		end else if (in_take) begin
			if (last_byte) begin
				blk_cnt_q   <= '0;
				frame_cnt_q <= '0;
				partial_q   <= '0;
			end else begin
				blk_cnt_q   <= count;
				frame_cnt_q <= (pos_inc >= frame) ? '0 : pos_inc;
				// only the leading bytes of a multi-byte sample are held
				if (pos_inc < bps) begin
					if (pos == '0) begin
						partial_q <= {8'd0, pcm_byte};
					end else begin
						partial_q <= {pcm_byte, partial_q[7:0]};
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/pbpe_queue.sv @@
`default_nettype none

`include "pcm_block_peak_envelope_macros.svh"

module pbpe_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire pbpe_pkg::entry_t  wr_entry,
	output logic                   full,
	output logic                   rd_vld,
	input  wire logic              pop,
	output pbpe_pkg::entry_t       rd_entry
);
	import pbpe_pkg::*;

	entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_vld   = (cnt_q != '0);
	assign rd_entry = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_vld;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
		end
	end

	`PBPE_ASSERT_NOW(a_no_overflow, push, !full, "queue push while full")
	`PBPE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count out of range")
	`PBPE_ASSERT_NEXT(a_cnt_step, do_push && !do_pop, cnt_q == $past(cnt_q) + QCNT_W'(1),
		"queue count missed a push")

endmodule

`default_nettype wire

@@ hdl/pbpe_back.sv @@
`default_nettype none

`include "pcm_block_peak_envelope_macros.svh"

module pbpe_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_vld,
	input  wire pbpe_pkg::entry_t  q_entry,
	output logic                   q_pop,
	output logic                   out_vld,
	input  wire logic              out_rdy,
	output logic                   block_valid,
	output logic signed [23:0]     block_low,
	output logic [22:0]            block_high,
	output logic [23:0]            span_least,
	output logic [23:0]            span_most,
	output logic                   stream_done
);
	import pbpe_pkg::*;

	logic signed [SAMPLE_W-1:0] run_low_q;
	logic signed [SAMPLE_W-1:0] run_high_q;
	logic signed [SAMPLE_W-1:0] new_low;
	logic signed [SAMPLE_W-1:0] new_high;
	block_t                     blk_s1;
	logic                       blk_vld_s1;
	logic [23:0]                least_q;
	logic [23:0]                most_q;
	logic [23:0]                span;
	logic [23:0]                least_new;
	logic [23:0]                most_new;
	logic                       out_vld_q;
	logic                       s2_go;
	logic                       s1_free;
	logic                       has_result;

	// Stage A: fold the sample into the running min and max.
	always_comb begin
		new_low  = run_low_q;
		new_high = run_high_q;
		if (q_entry.sample_vld) begin
			if (q_entry.sample > run_high_q) begin
				new_high = q_entry.sample;
			end else if (q_entry.sample < run_low_q) begin
				new_low = q_entry.sample;
			end
		end
	end

	assign s2_go      = !out_vld_q || out_rdy;
	assign s1_free    = !blk_vld_s1 || s2_go;
	assign has_result = q_entry.blk_end || q_entry.strm_end;
	assign q_pop      = q_vld && (!has_result || s1_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_low_q  <= '0;
			run_high_q <= '0;
			blk_vld_s1 <= 1'b0;
		end else begin
			if (q_pop && has_result) begin
				blk_vld_s1 <= 1'b1;
			end else if (s2_go) begin
				blk_vld_s1 <= 1'b0;
			end
			if (q_pop) begin
				if (has_result) begin
					run_low_q  <= '0;
					run_high_q <= '0;
				end else begin
					run_low_q  <= new_low;
					run_high_q <= new_high;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && has_result) begin
			blk_s1.blk_valid <= q_entry.blk_end;
			blk_s1.low       <= q_entry.blk_end ? new_low : '0;
			blk_s1.high      <= q_entry.blk_end ? new_high : '0;
			blk_s1.done      <= q_entry.strm_end;
		end
	end

	// Stage B: span of the closed block against the stream extremes.
	always_comb begin
		span      = 24'(blk_s1.high - blk_s1.low);
		least_new = least_q;
		most_new  = most_q;
		if (blk_s1.blk_valid) begin
			if (span < least_q) begin
				least_new = span;
			end
			if (span > most_q) begin
				most_new = span;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			least_q   <= SPAN_LEAST_RESET;
			most_q    <= '0;
			out_vld_q <= 1'b0;
		end else if (s2_go) begin
			out_vld_q <= blk_vld_s1;
			if (blk_vld_s1) begin
				least_q <= blk_s1.done ? SPAN_LEAST_RESET : least_new;
				most_q  <= blk_s1.done ? '0 : most_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && blk_vld_s1) begin
			block_valid <= blk_s1.blk_valid;
			block_low   <= blk_s1.low;
			block_high  <= blk_s1.high[22:0];
			span_least  <= least_new;
			span_most   <= most_new;
			stream_done <= blk_s1.done;
		end
	end

	assign out_vld = out_vld_q;

	`PBPE_ASSERT_NOW(a_low_nonpos, 1'b1, run_low_q[SAMPLE_W-1] || run_low_q == '0,
		"running minimum above zero")
	`PBPE_ASSERT_NOW(a_high_nonneg, 1'b1, !run_high_q[SAMPLE_W-1], "running maximum below zero")
	`PBPE_ASSERT_NOW(a_tail_closes, out_vld_q && !block_valid,
		stream_done && block_low == '0 && block_high == '0, "partial tail result malformed")
	`PBPE_ASSERT_NEXT(a_stream_reset, out_vld_q && out_rdy && stream_done && !blk_vld_s1,
		least_q == SPAN_LEAST_RESET && most_q == '0, "spans not cleared after stream end")

endmodule

`default_nettype wire

@@ hdl/pcm_block_peak_envelope.sv @@
`default_nettype none

// Peak envelope of a little-endian PCM byte stream. Bytes arrive one per item
// on the s_ side; the first channel of each frame is decoded (unsigned 8-bit
// less 128, signed 16-bit or signed 24-bit) and each block of block_bytes bytes
// yields one result on the m_ side with the block minimum and maximum (both
// clipped at zero) and the smallest (capped at 32767) and largest block span
// seen so far in the stream. A byte with s_tlast set closes the stream: if it
// does not end a full block a result with tuser low and zero min/max is sent,
// and all spans start over. The block takes one byte every clock cycle while
// s_tready is high; a block's last byte passes the queue, the stage A block
// register and the span stage output register before m_tvalid rises, later
// while earlier results wait on m_tready. Between the byte decoder and the
// min/max and span datapath sits a four-entry queue, so the input keeps flowing
// while a result waits on m_tready; s_tready drops only once that queue is full.
// Write configuration (index 0 sample width, 1 channels, 2 block length) only
// while no bytes are in flight; writes take effect at once and are always taken.

module pcm_block_peak_envelope (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration write channel
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [15:0]  cfg_data,
	// byte input
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] pcm_byte
	input  wire logic         s_tlast,   // stream_end
	// result output
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [95:0]       m_tdata,   // [23:0] block_low, [46:24] block_high,
	                                     // [70:47] span_least, [94:71] span_most, [95] zero
	output logic              m_tuser,   // block_valid
	output logic              m_tlast    // stream_done
);
	import pbpe_pkg::*;

	cfg_t   cfg_q;
	entry_t push_entry;
	entry_t q_entry;
	logic   push;
	logic   q_full;
	logic   q_vld;
	logic   q_pop;
	logic   in_take;

	logic signed [23:0] block_low;
	logic [22:0]        block_high;
	logic [23:0]        span_least;
	logic [23:0]        span_most;

	assign cfg_ready = 1'b1;

	// Hold register values; drop writes to indexes past the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_width <= WIDTH_S16;
			cfg_q.channels     <= 4'd2;
			cfg_q.block_bytes  <= 16'd2352;
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_SAMPLE_WIDTH: cfg_q.sample_width <= cfg_data[1:0];
				REG_CHANNELS:     cfg_q.channels     <= cfg_data[3:0];
				REG_BLOCK_BYTES:  cfg_q.block_bytes  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign in_take  = s_tvalid && s_tready;

	pbpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_take    (in_take),
		.pcm_byte   (s_tdata),
		.stream_end (s_tlast),
		.push       (push),
		.entry      (push_entry)
	);

	pbpe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.full     (q_full),
		.rd_vld   (q_vld),
		.pop      (q_pop),
		.rd_entry (q_entry)
	);

	pbpe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_vld       (q_vld),
		.q_entry     (q_entry),
		.q_pop       (q_pop),
		.out_vld     (m_tvalid),
		.out_rdy     (m_tready),
		.block_valid (m_tuser),
		.block_low   (block_low),
		.block_high  (block_high),
		.span_least  (span_least),
		.span_most   (span_most),
		.stream_done (m_tlast)
	);

	// Pack result fields from the lowest bit up; pad the top bit with zero.
	assign m_tdata = {1'b0, span_most, span_least, block_high, block_low};

endmodule

`default_nettype wire
